// File: sv/sync_serial_io_channel_assert.svh
// Assertion macros for the synchronous serial I/O channel.
// Used by the top level only; expands to nothing in synthesis.
`ifndef SYNC_SERIAL_IO_CHANNEL_ASSERT_SVH
`define SYNC_SERIAL_IO_CHANNEL_ASSERT_SVH
`ifndef SYNTHESIS
`define SSIO_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssio assertion failed");
`define SSIO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssio assertion failed");
`else
`define SSIO_ASSERT_IMP(label, ante, cons)
`define SSIO_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: sv/ssio_pkg.sv
// Types and constants shared by the serial I/O channel modules.
// No dependencies.
package ssio_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_EXT_CLK  = 2'd1,
    FUNC_RXD      = 2'd2,
    FUNC_TX_WRITE = 2'd3
  } func_t;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_CONTROL = 2'd1;
  localparam logic [1:0] REG_BAUD    = 2'd2;
  localparam logic [1:0] REG_SCLK_EN = 2'd3;

  localparam logic [3:0] RX_BITS_FULL = 4'd8;
  localparam logic [2:0] TX_BITS_LOAD = 3'd7;

  typedef struct packed {
    logic [7:0] sio_mode;
    logic [7:0] serial_control;
    logic [7:0] baud_control;
    logic       sclk_pin_enabled;
  } cfg_t;

  typedef struct packed {
    logic rx_restart;
    logic prescale_clear;
  } cfg_evt_t;

  typedef struct packed {
    func_t      func;
    logic       level;
    logic [7:0] tx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       xmit_go_drv;
    logic       xmit_go;
    logic       rx_done_int;
    logic       tx_done_int;
    logic       sclk_out;
    logic       txd;
  } res_t;

endpackage

// File: sv/ssio_cfg.sv
// Configuration register file of the serial I/O channel.
// Depends on ssio_pkg.
module ssio_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_addr,
  input  logic [7:0]          cfg_wdata,
  output ssio_pkg::cfg_t      cfg,
  output ssio_pkg::cfg_evt_t  cfg_evt
);
  import ssio_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:    cfg_nxt.sio_mode         = cfg_wdata;
        REG_CONTROL: cfg_nxt.serial_control   = cfg_wdata;
        REG_BAUD:    cfg_nxt.baud_control     = cfg_wdata;
        REG_SCLK_EN: cfg_nxt.sclk_pin_enabled = cfg_wdata[0];
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // side effects of a write; the core applies them only while it steps no word
  assign cfg_evt.rx_restart     = cfg_we && (cfg_addr == REG_CONTROL);
  assign cfg_evt.prescale_clear = cfg_we && (cfg_addr == REG_BAUD);
  assign cfg = cfg_r;

endmodule

// File: sv/ssio_core.sv
// Channel state and single-pass update for one word: prescaler, clock
// edges, receive and transmit shift registers. Depends on ssio_pkg.
module ssio_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  ssio_pkg::item_t    item,
  input  ssio_pkg::cfg_t     cfg,
  input  ssio_pkg::cfg_evt_t cfg_evt,
  output ssio_pkg::res_t     res
);
  import ssio_pkg::*;

  logic        clock_level_r, clock_level_nxt;
  logic [3:0]  rx_bits_left_r, rx_bits_left_nxt;
  logic [7:0]  rx_shift_r, rx_shift_nxt;
  logic [7:0]  rx_hold_r, rx_hold_nxt;
  logic        rxd_level_r, rxd_level_nxt;
  logic [2:0]  tx_bits_left_r, tx_bits_left_nxt;
  logic [7:0]  tx_shift_r, tx_shift_nxt;
  logic        txd_level_r, txd_level_nxt;
  logic        skip_fall_r, skip_fall_nxt;
  logic        trail_due_r, trail_due_nxt;
  logic [11:0] prescale_cnt_r, prescale_cnt_nxt;

  logic [3:0]  divisor;
  logic [11:0] period;
  logic [11:0] cnt_inc;
  logic        clk_gated;
  logic        pending;
  logic        edge_req;
  logic        edge_lvl;
  logic        tx_idle;
  logic [3:0]  rx_dec;
  logic [7:0]  rx_shift_in;
  logic        tx_done;
  logic        rx_done;
  logic        start;
  logic        driven;

  assign divisor   = cfg.baud_control[3:0];
  assign cnt_inc   = prescale_cnt_r + 12'd1;
  assign clk_gated = (cfg.sio_mode[1:0] == 2'b00) && cfg.serial_control[0];
  assign pending   = (tx_bits_left_r != 3'd0) || skip_fall_r ||
                     (rx_bits_left_r != RX_BITS_FULL) || trail_due_r;
  assign tx_idle   = (tx_bits_left_r == 3'd0);
  assign rx_dec    = rx_bits_left_r - 4'd1;
  assign rx_shift_in = {rxd_level_r, rx_shift_r[7:1]};

  // period = divisor * 4^(k+1)
  always_comb begin
    case (cfg.baud_control[5:4])
      2'd0:    period = {6'd0, divisor, 2'd0};
      2'd1:    period = {4'd0, divisor, 4'd0};
      2'd2:    period = {2'd0, divisor, 6'd0};
      2'd3:    period = {divisor, 8'd0};
      default: period = '0;
    endcase
  end

  always_comb begin
    clock_level_nxt  = clock_level_r;
    rx_bits_left_nxt = rx_bits_left_r;
    rx_shift_nxt     = rx_shift_r;
    rx_hold_nxt      = rx_hold_r;
    rxd_level_nxt    = rxd_level_r;
    tx_bits_left_nxt = tx_bits_left_r;
    tx_shift_nxt     = tx_shift_r;
    txd_level_nxt    = txd_level_r;
    skip_fall_nxt    = skip_fall_r;
    trail_due_nxt    = trail_due_r;
    prescale_cnt_nxt = prescale_cnt_r;
    edge_req = 1'b0;
    edge_lvl = 1'b0;
    tx_done  = 1'b0;
    rx_done  = 1'b0;
    start    = 1'b0;
    driven   = 1'b0;

    if (step_en) begin
      case (item.func)
        FUNC_TICK: begin
          if (divisor != 4'd0) begin
            prescale_cnt_nxt = cnt_inc;
            if (cnt_inc >= period) begin
              prescale_cnt_nxt = '0;
              if (!clk_gated && pending) begin
                edge_req = 1'b1;
                edge_lvl = ~clock_level_r;
              end
            end
          end
        end
        FUNC_EXT_CLK: begin
          // a level equal to the current one is no edge
          if (item.level != clock_level_r) begin
            edge_req = 1'b1;
            edge_lvl = item.level;
          end
        end
        FUNC_RXD: rxd_level_nxt = item.level;
        FUNC_TX_WRITE: begin
          tx_shift_nxt     = item.tx_byte;
          tx_bits_left_nxt = TX_BITS_LOAD;
          txd_level_nxt    = item.tx_byte[0];
          start            = tx_idle;
          driven           = tx_idle && cfg.sclk_pin_enabled;
          skip_fall_nxt    = tx_idle && clock_level_r;
        end
        default: begin
          edge_req = 1'b0;
        end
      endcase
    end else begin
      if (cfg_evt.rx_restart) begin
        rx_bits_left_nxt = RX_BITS_FULL;
      end
      if (cfg_evt.prescale_clear) begin
        prescale_cnt_nxt = '0;
      end
    end

    if (edge_req) begin
      clock_level_nxt = edge_lvl;
      if (edge_lvl) begin
        // rising: finish a deferred transmit, sample RXD
        if (trail_due_r) begin
          trail_due_nxt = 1'b0;
          tx_done       = 1'b1;
        end
        if (rx_bits_left_r != 4'd0) begin
          rx_shift_nxt = rx_shift_in;
          if (rx_dec == 4'd0) begin
            rx_bits_left_nxt = RX_BITS_FULL;
            rx_hold_nxt      = rx_shift_in;
            rx_done          = 1'b1;
          end else begin
            rx_bits_left_nxt = rx_dec;
          end
        end
      end else if (!tx_idle) begin
        // falling: shift out next bit unless this edge is skipped
        if (skip_fall_r) begin
          skip_fall_nxt = 1'b0;
        end else begin
          tx_shift_nxt     = {1'b0, tx_shift_r[7:1]};
          txd_level_nxt    = tx_shift_r[1];
          tx_bits_left_nxt = tx_bits_left_r - 3'd1;
          if (tx_bits_left_r == 3'd1) begin
            trail_due_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_level_r  <= 1'b0;
      rx_bits_left_r <= RX_BITS_FULL;
      rx_shift_r     <= '0;
      rx_hold_r      <= '0;
      rxd_level_r    <= 1'b0;
      tx_bits_left_r <= '0;
      tx_shift_r     <= '0;
      txd_level_r    <= 1'b1;
      skip_fall_r    <= 1'b0;
      trail_due_r    <= 1'b0;
      prescale_cnt_r <= '0;
    end else begin
      clock_level_r  <= clock_level_nxt;
      rx_bits_left_r <= rx_bits_left_nxt;
      rx_shift_r     <= rx_shift_nxt;
      rx_hold_r      <= rx_hold_nxt;
      rxd_level_r    <= rxd_level_nxt;
      tx_bits_left_r <= tx_bits_left_nxt;
      tx_shift_r     <= tx_shift_nxt;
      txd_level_r    <= txd_level_nxt;
      skip_fall_r    <= skip_fall_nxt;
      trail_due_r    <= trail_due_nxt;
      prescale_cnt_r <= prescale_cnt_nxt;
    end
  end

  assign res.txd         = txd_level_nxt;
  assign res.sclk_out    = clock_level_nxt;
  assign res.tx_done_int = tx_done;
  assign res.rx_done_int = rx_done;
  assign res.xmit_go     = start;
  assign res.xmit_go_drv = driven;
  assign res.rx_byte     = rx_hold_nxt;

endmodule

// File: sv/sync_serial_io_channel.sv
// Top level of the synchronous serial I/O channel: input word register,
// result register and assertions. Uses ssio_pkg, ssio_cfg, ssio_core.
//
//  channel | ports                         | word
//  --------+-------------------------------+------------------------------------
//  input   | in_tvalid/in_tready           | tuser: func; tdata: level, tx_byte
//  result  | out_tvalid/out_tready         | tdata: txd .. rx_byte (see port)
//  config  | cfg_we, cfg_addr, cfg_wdata   | one register per write, no wait
//
// One word per cycle sustained while results are taken; each word passes the input
// register, then the state update into the result register.
// Synchronous active-low reset clears all state but the word payload registers;
// txd resets high, receive count resets to eight. A stalled result holds the
// result register and, once the input register is also full, in_tready drops.
`include "sync_serial_io_channel_assert.svh"
module sync_serial_io_channel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] func
  input  logic [15:0] in_tdata,   // [0] level, [8:1] tx_byte, [15:9] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] txd, [1] sclk_out, [2] tx_done_int,
                                  // [3] rx_done_int, [4] xmit_go,
                                  // [5] xmit_go_drv, [13:6] rx_byte,
                                  // [15:14] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);
  import ssio_pkg::*;

  cfg_t     cfg;
  cfg_evt_t cfg_evt;
  res_t     res;

  logic  in_valid_r, in_valid_nxt;
  item_t item_r, item_nxt;
  logic  out_valid_r, out_valid_nxt;
  res_t  out_data_r, out_data_nxt;
  logic  advance;
  logic  in_take;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  ssio_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .cfg_evt   (cfg_evt)
  );

  ssio_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .cfg_evt (cfg_evt),
    .res     (res)
  );

  always_comb begin
    in_valid_nxt = in_take || (in_valid_r && !advance);
    item_nxt     = item_r;
    if (in_take) begin
      item_nxt.func    = func_t'(in_tuser);
      item_nxt.level   = in_tdata[0];
      item_nxt.tx_byte = in_tdata[8:1];
    end
    out_valid_nxt = advance || (out_valid_r && !out_tready);
    out_data_nxt  = advance ? res : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

  `SSIO_ASSERT_IMP(a_stall_only_when_full, !in_tready, in_valid_r && out_valid_r && !out_tready)
  `SSIO_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_r)
  `SSIO_ASSERT_IMP(a_start_not_with_edge, out_valid_r && out_data_r.xmit_go,
                   !out_data_r.tx_done_int && !out_data_r.rx_done_int)
  `SSIO_ASSERT_IMP(a_driven_needs_start, out_valid_r && out_data_r.xmit_go_drv,
                   out_data_r.xmit_go)

endmodule

// File: test/sync_serial_io_channel_tb.sv
// Testbench for sync_serial_io_channel: drives pin, tick and transmit words, predicts
// every result word from its own copy of the channel state and checks it field by field.
// Depends on ssio_pkg and the sync_serial_io_channel RTL.
module sync_serial_io_channel_tb;
  import ssio_pkg::*;

  localparam int LIMIT_CYCLES = 200000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [7:0]  cfg_wdata;

  sync_serial_io_channel dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // channel registers and state as the predictor sees them
  logic [7:0]  r_mode, r_ctrl, r_baud;
  logic        r_sclk_en;
  logic        sclk_lvl, rxd_lvl, txd_lvl, skip_fall, trail_due;
  logic [3:0]  rx_left;
  logic [7:0]  rx_sr, rx_hold, tx_sr;
  logic [2:0]  tx_left;
  logic [11:0] presc_cnt;
  logic        ev_tx_done, ev_rx_done;

  res_t expected_words[$];
  res_t exp_w, got_w;

  int errors = 0;
  int cycle_cnt = 0;
  int n_words = 0;
  int n_checked = 0;
  int n_starts = 0;
  int n_tx_done = 0;
  int n_rx_done = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void serial_edge(logic lvl);
    if (lvl != sclk_lvl) begin
      sclk_lvl = lvl;
      if (lvl) begin
        if (trail_due) begin
          trail_due = 1'b0;
          ev_tx_done = 1'b1;
        end
        if (rx_left != 4'd0) begin
          rx_left = rx_left - 4'd1;
          rx_sr = {rxd_lvl, rx_sr[7:1]};
          if (rx_left == 4'd0) begin
            rx_left = RX_BITS_FULL;
            rx_hold = rx_sr;
            ev_rx_done = 1'b1;
          end
        end
      end else if (tx_left != 3'd0) begin
        // the first falling edge after a start with the clock high is not a shift
        if (skip_fall) begin
          skip_fall = 1'b0;
        end else begin
          tx_sr = tx_sr >> 1;
          txd_lvl = tx_sr[0];
          tx_left = tx_left - 3'd1;
          if (tx_left == 3'd0) trail_due = 1'b1;
        end
      end
    end
  endfunction

  function automatic void prescale_tick();
    int period;
    logic busy;
    if (r_baud[3:0] != 4'd0) begin
      period = int'(r_baud[3:0]) << (2 * (int'(r_baud[5:4]) + 1));
      presc_cnt = presc_cnt + 12'd1;
      if (int'(presc_cnt) >= period) begin
        presc_cnt = '0;
        busy = (tx_left != 3'd0) || skip_fall || (rx_left != RX_BITS_FULL) || trail_due;
        // trigger mode with external clock selected: count but never toggle
        if (!(r_mode[1:0] == 2'd0 && r_ctrl[0]) && busy) serial_edge(~sclk_lvl);
      end
    end
  endfunction

  function automatic res_t channel_step(func_t f, logic lvl, logic [7:0] b);
    res_t r;
    logic tx_free;
    r = '0;
    ev_tx_done = 1'b0;
    ev_rx_done = 1'b0;
    case (f)
      FUNC_TICK: prescale_tick();
      FUNC_EXT_CLK: serial_edge(lvl);
      FUNC_RXD: rxd_lvl = lvl;
      default: begin
        tx_free = (tx_left == 3'd0);
        tx_sr = b;
        tx_left = TX_BITS_LOAD;
        if (tx_free) begin
          r.xmit_go = 1'b1;
          r.xmit_go_drv = r_sclk_en;
          n_starts++;
        end
        txd_lvl = b[0];
        skip_fall = tx_free && sclk_lvl;
      end
    endcase
    r.txd = txd_lvl;
    r.sclk_out = sclk_lvl;
    r.tx_done_int = ev_tx_done;
    r.rx_done_int = ev_rx_done;
    r.rx_byte = rx_hold;
    n_tx_done += int'(ev_tx_done);
    n_rx_done += int'(ev_rx_done);
    return r;
  endfunction

  function automatic void apply_reg(logic [1:0] a, logic [7:0] d);
    case (a)
      REG_MODE: r_mode = d;
      REG_CONTROL: begin
        r_ctrl = d;
        rx_left = RX_BITS_FULL;
      end
      REG_BAUD: begin
        r_baud = d;
        presc_cnt = '0;
      end
      REG_SCLK_EN: r_sclk_en = d[0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] e, logic [7:0] a);
    if (a !== e) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, e, a);
    end
  endfunction

  // receiver side: stall at the configured rate
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: result word %0h with nothing expected", $time, out_tdata);
      end else begin
        exp_w = expected_words.pop_front();
        got_w = res_t'(out_tdata[13:0]);
        check_field("txd", exp_w.txd, got_w.txd);
        check_field("sclk_out", exp_w.sclk_out, got_w.sclk_out);
        check_field("tx_done_int", exp_w.tx_done_int, got_w.tx_done_int);
        check_field("rx_done_int", exp_w.rx_done_int, got_w.rx_done_int);
        check_field("xmit_go", exp_w.xmit_go, got_w.xmit_go);
        check_field("xmit_go_drv", exp_w.xmit_go_drv, got_w.xmit_go_drv);
        check_field("rx_byte", exp_w.rx_byte, got_w.rx_byte);
        check_field("padding", 8'd0, {6'd0, out_tdata[15:14]});
        n_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_word(func_t f, logic lvl, logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = f;
    in_tdata = {7'd0, b, lvl};
    do @(posedge clk); while (!in_tready);
    expected_words.push_back(channel_step(f, lvl, b));
    n_words++;
  endtask

  // drop valid and wait for every outstanding result, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] a, logic [7:0] d);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = a;
    cfg_wdata = d;
    @(posedge clk);
    apply_reg(a, d);
  endtask

  task automatic configure(logic [7:0] mode, logic [7:0] ctrl, logic [7:0] baud, logic en);
    drain();
    write_reg(REG_MODE, mode);
    write_reg(REG_CONTROL, ctrl);
    write_reg(REG_BAUD, baud);
    write_reg(REG_SCLK_EN, {7'd0, en});
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_traffic(int n, int src_pct, int snk_pct, bit ext_clk);
    int r;
    func_t f;
    logic lvl;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      lvl = 1'($urandom_range(1));
      if (ext_clk)
        f = (r < 25) ? FUNC_TICK : (r < 60) ? FUNC_EXT_CLK : (r < 80) ? FUNC_RXD : FUNC_TX_WRITE;
      else
        f = (r < 78) ? FUNC_TICK : (r < 84) ? FUNC_EXT_CLK : (r < 94) ? FUNC_RXD : FUNC_TX_WRITE;
      // outside external-clock runs, let most transfers run to the end before the next byte is written
      if (!ext_clk && f == FUNC_TX_WRITE && tx_left != 3'd0 && $urandom_range(3) != 0)
        f = FUNC_TICK;
      // mostly real edges on the external clock line
      if (f == FUNC_EXT_CLK && $urandom_range(4) != 0) lvl = ~sclk_lvl;
      send_word(f, lvl, 8'($urandom_range(255)));
    end
  endtask

  task automatic test_pin_events();
    configure(8'h00, 8'h00, 8'h00, 1'b1);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    send_word(FUNC_TICK, 1'b0, 8'h00);       // stopped prescaler
    send_word(FUNC_EXT_CLK, 1'b0, 8'h00);    // unchanged level
    send_word(FUNC_RXD, 1'b1, 8'h00);
    send_word(FUNC_EXT_CLK, 1'b1, 8'hff);
    send_word(FUNC_TX_WRITE, 1'b1, 8'hff);   // start with clock high: skip a fall
    send_word(FUNC_EXT_CLK, 1'b0, 8'h00);
    send_word(FUNC_EXT_CLK, 1'b1, 8'h00);
    send_word(FUNC_EXT_CLK, 1'b0, 8'h00);
    send_word(FUNC_TX_WRITE, 1'b0, 8'h00);   // write during transfer
    send_word(FUNC_RXD, 1'b0, 8'h00);
    for (int i = 0; i < 8; i++) send_word(FUNC_EXT_CLK, ~sclk_lvl, 8'h00);
  endtask

  task automatic test_prescaler();
    configure(8'h00, 8'h01, 8'h01, 1'b0);    // external clock in trigger mode
    for (int i = 0; i < 4; i++) send_word(FUNC_TICK, 1'b0, 8'h00);
    configure(8'h00, 8'h00, 8'h01, 1'b0);
    for (int i = 0; i < 4; i++) send_word(FUNC_TICK, 1'b1, 8'h00);
  endtask

  task automatic test_traffic_no_idle();
    configure(8'h01, 8'h00, 8'h01, 1'b1);
    run_traffic(120, 0, 0, 1'b0);
  endtask

  task automatic test_traffic_sender_idle();
    configure(8'h00, 8'h00, 8'h02, 1'b0);
    run_traffic(120, 87, 0, 1'b0);
  endtask

  task automatic test_traffic_receiver_stall();
    configure(8'h00, 8'h01, 8'h10, 1'b1);
    run_traffic(120, 0, 87, 1'b1);
  endtask

  task automatic test_traffic_both_idle();
    configure(8'h03, 8'hfe, 8'h11, 1'b0);
    run_traffic(110, 11, 11, 1'b0);
  endtask

  task automatic test_register_extremes();
    configure(8'hff, 8'hff, 8'hff, 1'b0);
    run_traffic(30, 0, 0, 1'b1);
    configure(8'h00, 8'h00, 8'h00, 1'b1);
    run_traffic(20, 0, 0, 1'b1);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    r_mode = '0;
    r_ctrl = '0;
    r_baud = '0;
    r_sclk_en = 1'b0;
    sclk_lvl = 1'b0;
    rx_left = RX_BITS_FULL;
    rx_sr = '0;
    rx_hold = '0;
    rxd_lvl = 1'b0;
    tx_left = '0;
    tx_sr = '0;
    txd_lvl = 1'b1;
    skip_fall = 1'b0;
    trail_due = 1'b0;
    presc_cnt = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_pin_events();
    test_prescaler();
    test_traffic_no_idle();
    test_traffic_sender_idle();
    test_traffic_receiver_stall();
    test_traffic_both_idle();
    test_register_extremes();

    drain();
    repeat (8) @(posedge clk);
    if (expected_words.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_words.size());
    end
    $display("sent %0d words and checked %0d results over seven tests", n_words, n_checked);
    $display("saw %0d transmit starts, %0d tx done and %0d rx done pulses",
             n_starts, n_tx_done, n_rx_done);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/ssio_pkg.sv
sv/ssio_cfg.sv
sv/ssio_core.sv
sv/sync_serial_io_channel.sv
test/sync_serial_io_channel_tb.sv
